// ===== sv/cbtn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbtn_pkg;

   localparam int MAX_INTERFACES = 16;
   localparam int IDX_W = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
   localparam int CNT_W = $clog2(MAX_INTERFACES + 1);

   localparam int TICK_W = 64;
   localparam int RES_W = 32;
   localparam int USEC_W = 20;
   localparam int PROD_W = RES_W + USEC_W;
   localparam int STEP_W = $clog2(TICK_W);

   localparam logic [STEP_W-1:0] SEC_STEP_LAST = STEP_W'(TICK_W - 1);
   localparam logic [STEP_W-1:0] FRAC_STEP_LAST = STEP_W'(USEC_W - 1);

   localparam logic [RES_W-1:0] DEFAULT_RES_RESET = 32'd1000000;
   localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

   localparam int RESOL_BASE2_BIT = 7;
   localparam logic [6:0] MAX_EXP2 = 7'd31;
   localparam logic [6:0] MAX_EXP10 = 7'd9;

   localparam logic [2:0] ST_IFACE_OK = 3'd0;
   localparam logic [2:0] ST_IFACE_DEFAULT = 3'd1;
   localparam logic [2:0] ST_TABLE_FULL = 3'd2;
   localparam logic [2:0] ST_PACKET_OK = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;
   localparam logic [2:0] ST_BAD_IFACE = 3'd5;

   localparam logic CMD_IFACE = 1'b0;

   typedef struct packed {
      logic        cmd;
      logic        resol_present;
      logic [7:0]  resol_code;
      logic [31:0] iface_index;
      logic [31:0] stamp_high;
      logic [31:0] stamp_low;
      logic [31:0] captured_len;
      logic [31:0] original_len;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [TICK_W-1:0] seconds;
      logic [USEC_W-1:0] microseconds;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DIV_SEC,
      S_MULT,
      S_FRAC_LOAD,
      S_DIV_FRAC,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic div_step;
      logic mult;
      logic frac_load;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic pkt_go;
   } dp_sts_type;

   function automatic logic [RES_W-1:0] pow10(input logic [3:0] expo);
      logic [RES_W-1:0] r;
      unique case (expo)
         4'd0:    r = 32'd1;
         4'd1:    r = 32'd10;
         4'd2:    r = 32'd100;
         4'd3:    r = 32'd1000;
         4'd4:    r = 32'd10000;
         4'd5:    r = 32'd100000;
         4'd6:    r = 32'd1000000;
         4'd7:    r = 32'd10000000;
         4'd8:    r = 32'd100000000;
         4'd9:    r = 32'd1000000000;
         default: r = 32'd1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/cbtn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbtn_ctrl
   import cbtn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd,
   output logic            busy
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (sts.pkt_go) begin
               state_in = S_DIV_SEC;
               step_in = SEC_STEP_LAST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV_SEC: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) state_in = S_MULT;
            else step_in = step_ff - 1'b1;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_FRAC_LOAD;
         end
         S_FRAC_LOAD: begin
            cmd.frac_load = 1'b1;
            step_in = FRAC_STEP_LAST;
            state_in = S_DIV_FRAC;
         end
         S_DIV_FRAC: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) state_in = S_FINISH;
            else step_in = step_ff - 1'b1;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/cbtn_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbtn_dp
   import cbtn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire logic        csr_valid,
   input  wire logic [31:0] csr_data,
   input  wire dp_cmd_type  cmd,
   output dp_sts_type       sts,
   output rsp_type          rsp_data,
   output logic             rsp_valid
);

   req_type           req_ff, req_in;
   logic [RES_W-1:0]  def_res_ff, def_res_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [RES_W-1:0]  table_ff [MAX_INTERFACES];
   logic [RES_W-1:0]  divisor_ff, divisor_in;
   logic [RES_W-1:0]  rem_ff, rem_in;
   logic [TICK_W-1:0] quo_ff, quo_in;
   logic [TICK_W-1:0] secs_ff, secs_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              tbl_we;
   logic [IDX_W-1:0]  tbl_wa;

   logic [6:0]        expo;
   logic              base2;
   logic              code_ok;
   logic              use_code;
   logic [RES_W-1:0]  code_res;
   logic [RES_W-1:0]  new_res;
   logic              table_full;
   logic              empty;
   logic              bad;
   logic [RES_W+1:0]  diff;
   logic              ge;
   logic [RES_W-1:0]  rem_next;

   assign expo = req_ff.resol_code[6:0];
   assign base2 = req_ff.resol_code[RESOL_BASE2_BIT];
   assign code_ok = base2 ? (expo <= MAX_EXP2) : (expo <= MAX_EXP10);
   assign code_res = base2 ? (32'd1 << expo[4:0]) : pow10(expo[3:0]);
   assign use_code = req_ff.resol_present & code_ok;
   assign new_res = use_code ? code_res : def_res_ff;
   assign table_full = (count_ff == CNT_W'(MAX_INTERFACES));
   assign empty = (req_ff.captured_len == '0) || (req_ff.original_len == '0);
   // count never exceeds the table depth, so this also bounds the index
   assign bad = (req_ff.iface_index >= 32'(count_ff));
   assign tbl_wa = count_ff[IDX_W-1:0];

   assign sts.pkt_go = (req_ff.cmd != CMD_IFACE) && !empty && !bad;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign diff = {1'b0, rem_ff, quo_ff[TICK_W-1]} - {2'b00, divisor_ff};
   assign ge = !diff[RES_W+1];
   assign rem_next = ge ? diff[RES_W-1:0] : {rem_ff[RES_W-2:0], quo_ff[TICK_W-1]};

   always_comb begin
      req_in = cmd.capture ? req_data : req_ff;
      def_res_in = def_res_ff;
      if (csr_valid) def_res_in = (csr_data == '0) ? 32'd1 : csr_data;
      count_in = count_ff;
      tbl_we = 1'b0;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      secs_in = secs_ff;
      prod_in = prod_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;

      if (cmd.decode) begin
         if (req_ff.cmd == CMD_IFACE) begin
            rsp_in = '0;
            rsp_valid_in = 1'b1;
            if (table_full) begin
               rsp_in.status = ST_TABLE_FULL;
            end else begin
               tbl_we = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in.status = use_code ? ST_IFACE_OK : ST_IFACE_DEFAULT;
            end
         end else if (empty) begin
            rsp_in = '0;
            rsp_in.status = ST_EMPTY;
            rsp_valid_in = 1'b1;
         end else if (bad) begin
            rsp_in = '0;
            rsp_in.status = ST_BAD_IFACE;
            rsp_valid_in = 1'b1;
         end else begin
            divisor_in = table_ff[req_ff.iface_index[IDX_W-1:0]];
            rem_in = '0;
            quo_in = {req_ff.stamp_high, req_ff.stamp_low};
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_next;
         quo_in = {quo_ff[TICK_W-2:0], ge};
      end

      if (cmd.mult) begin
         secs_in = quo_ff;
         prod_in = rem_ff * USEC_PER_SEC;
      end

      // quotient of the fraction fits in USEC_W bits, so the top part starts as remainder
      if (cmd.frac_load) begin
         rem_in = prod_ff[PROD_W-1:USEC_W];
         quo_in = {prod_ff[USEC_W-1:0], (TICK_W - USEC_W)'(0)};
      end

      if (cmd.finish) begin
         rsp_in.status = ST_PACKET_OK;
         rsp_in.seconds = secs_ff;
         rsp_in.microseconds = quo_ff[USEC_W-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         def_res_ff <= DEFAULT_RES_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         def_res_ff <= def_res_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      secs_ff <= secs_in;
      prod_ff <= prod_in;
      rsp_ff <= rsp_in;
      if (tbl_we) table_ff[tbl_wa] <= new_res;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/capture_block_timestamp_normalizer.sv =====
// channel   ports                          transfer
// request   start, busy, req_data          start high while busy low
// response  rsp_valid, rsp_data            rsp_valid high, one cycle, no back-pressure
// csr       csr_valid, csr_ready, csr_data csr_valid and csr_ready high
//
// an interface block or a rejected packet passes through the decode state only, then goes idle
// a good packet goes through one shared restoring divider, one quotient bit per cycle,
// which runs 64 steps for seconds and 20 for microseconds, plus the decode, multiply,
// reload and finish states
// the response shows in the cycle busy drops, so the next request can overlap it
// synchronous reset clears the controller, interface count and strobe, and sets the default resolution to 1000000
`timescale 1ns / 1ps
`default_nettype none

module capture_block_timestamp_normalizer
   import cbtn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   cbtn_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   cbtn_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

`default_nettype wire

// ===== sv/cbtn_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbtn_chk
   import cbtn_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire rsp_type     rsp_data
);

   // a transfer always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not set after request transfer");

   // leaving busy always comes with a response
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_BAD_IFACE)
      else $error("response status out of range");

   a_zero_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_PACKET_OK
      |-> rsp_data.seconds == '0 && rsp_data.microseconds == '0)
      else $error("time fields set on a non-packet response");

   a_usec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_PACKET_OK |-> rsp_data.microseconds < USEC_PER_SEC)
      else $error("microseconds out of range");

endmodule

bind capture_block_timestamp_normalizer cbtn_chk u_chk (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import cbtn_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 100;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 52;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // predictor copy of the block state
   logic [31:0] rate_table [MAX_INTERFACES];
   int          iface_total = 0;
   logic [31:0] tick_rate_default = DEFAULT_RES_RESET;

   rsp_type     due_outcomes [$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          steady_feed = 1'b0;

   capture_block_timestamp_normalizer uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type convert_block(input req_type blk);
      rsp_type     outcome;
      logic [6:0]  expo;
      logic [31:0] rate;
      logic [63:0] ticks;
      logic [63:0] divisor;
      logic [63:0] rest;
      bit          usable;
      outcome = '0;
      if (blk.cmd == CMD_IFACE) begin
         if (iface_total >= MAX_INTERFACES) begin
            outcome.status = ST_TABLE_FULL;
         end else begin
            expo = blk.resol_code[6:0];
            usable = 1'b0;
            rate = tick_rate_default;
            if (blk.resol_present) begin
               if (blk.resol_code[RESOL_BASE2_BIT]) begin
                  if (expo <= MAX_EXP2) begin
                     usable = 1'b1;
                     rate = 32'd1 << expo;
                  end
               end else if (expo <= MAX_EXP10) begin
                  usable = 1'b1;
                  rate = 32'd1;
                  repeat (expo) rate = rate * 32'd10;
               end
            end
            outcome.status = usable ? ST_IFACE_OK : ST_IFACE_DEFAULT;
            rate_table[iface_total] = rate;
            iface_total++;
         end
      end else if (blk.captured_len == 0 || blk.original_len == 0) begin
         // empty length wins over a bad index
         outcome.status = ST_EMPTY;
      end else if (blk.iface_index >= 32'(iface_total)) begin
         outcome.status = ST_BAD_IFACE;
      end else begin
         ticks = {blk.stamp_high, blk.stamp_low};
         divisor = {32'd0, rate_table[blk.iface_index[IDX_W-1:0]]};
         rest = ticks % divisor;
         outcome.status = ST_PACKET_OK;
         outcome.seconds = ticks / divisor;
         outcome.microseconds = USEC_W'((rest * 64'(USEC_PER_SEC)) / divisor);
      end
      return outcome;
   endfunction

   function automatic logic [31:0] nonzero_word();
      logic [31:0] v;
      v = $urandom();
      return (v == 0) ? 32'd1 : v;
   endfunction

   function automatic req_type iface_block(input logic present, input logic [7:0] code);
      req_type blk;
      blk.cmd = CMD_IFACE;
      blk.resol_present = present;
      blk.resol_code = code;
      // packet fields are don't-care here, scramble them
      blk.iface_index = $urandom();
      blk.stamp_high = $urandom();
      blk.stamp_low = $urandom();
      blk.captured_len = $urandom();
      blk.original_len = $urandom();
      return blk;
   endfunction

   function automatic req_type make_packet(input logic [31:0] idx, input logic [31:0] hi,
                                           input logic [31:0] lo, input logic [31:0] cap,
                                           input logic [31:0] orig);
      req_type blk;
      blk.cmd = ~CMD_IFACE;
      blk.resol_present = 1'($urandom_range(0, 1));
      blk.resol_code = 8'($urandom_range(0, 255));
      blk.iface_index = idx;
      blk.stamp_high = hi;
      blk.stamp_low = lo;
      blk.captured_len = cap;
      blk.original_len = orig;
      return blk;
   endfunction

   task automatic pause_sender();
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (steady_feed || pick < 50) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 4);
      else if (pick < 97) gap = $urandom_range(5, 30);
      else gap = $urandom_range(40, 150);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_block(input req_type blk);
      if (!start) start <= 1'b1;
      req_data <= blk;
      do @(posedge clock); while (busy !== 1'b0);
      due_outcomes.push_back(convert_block(blk));
      pause_sender();
   endtask

   // hold the sender off until every outcome is back
   task automatic settle_block();
      if (start) start <= 1'b0;
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_default_rate(input logic [31:0] rate);
      settle_block();
      csr_valid <= 1'b1;
      csr_data <= rate;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      tick_rate_default = (rate == 0) ? 32'd1 : rate;
   endtask

   task automatic test_resolution_decode();
      send_block(iface_block(1'b0, 8'h83));   // option absent, code ignored
      send_block(iface_block(1'b1, 8'h80));   // 2^0
      send_block(iface_block(1'b1, 8'h9F));   // 2^31
      send_block(iface_block(1'b1, 8'hA0));   // 2^32 too wide
      send_block(iface_block(1'b1, 8'h00));   // 10^0
      send_block(iface_block(1'b1, 8'h09));   // 10^9
      send_block(iface_block(1'b1, 8'h0A));   // 10^10 too wide
      send_block(iface_block(1'b1, 8'hFF));
   endtask

   task automatic test_default_rate();
      write_default_rate(32'd0);              // zero is stored as one
      send_block(iface_block(1'b0, 8'h00));
      write_default_rate(32'hFFFF_FFFF);
      send_block(iface_block(1'b1, 8'h7F));
      write_default_rate(32'd1);
   endtask

   task automatic test_packet_checks();
      send_block(make_packet(32'd0, 32'd0, 32'd5, 32'd0, 32'd5));
      send_block(make_packet(32'd0, 32'd0, 32'd5, 32'd1, 32'd0));
      send_block(make_packet(32'hFFFF_FFFF, $urandom(), $urandom(), 32'd0, 32'd0));
      send_block(make_packet(32'(iface_total), $urandom(), $urandom(), 32'd64, 32'd64));
      send_block(make_packet(32'd16, $urandom(), $urandom(), 32'd64, 32'd1500));
      send_block(make_packet(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
   endtask

   task automatic test_time_conversion();
      send_block(make_packet(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd60, 32'd60));
      send_block(make_packet(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd60, 32'd60));
      send_block(make_packet(32'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd60, 32'd60));
      send_block(make_packet(32'd5, 32'd0, 32'd0, 32'd60, 32'd60));
      send_block(make_packet(32'd0, 32'h0000_011F, 32'h71FB_04CB, 32'd60, 32'd90));
      send_block(make_packet(32'd7, $urandom(), $urandom(), 32'd60, 32'd90));
   endtask

   task automatic test_random_traffic();
      int          pick;
      logic [31:0] rate;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [7:0]  code;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: rate = 32'd1;
            1: rate = 32'hFFFF_FFFF;
            2: rate = 32'd0;
            3: rate = DEFAULT_RES_RESET;
            default: rate = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000) : $urandom();
         endcase
         write_default_rate(rate);
         steady_feed = (phase % 4 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               // at least half the codes land in the usable range
               code[7] = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 1))
                  code[6:0] = code[7] ? 7'($urandom_range(0, 31)) : 7'($urandom_range(0, 9));
               else
                  code[6:0] = 7'($urandom_range(0, 127));
               send_block(iface_block($urandom_range(0, 99) < 85, code));
            end else if (pick < 15) begin
               case ($urandom_range(0, 2))
                  0: send_block(make_packet($urandom(), $urandom(), $urandom(),
                                            32'd0, nonzero_word()));
                  1: send_block(make_packet($urandom(), $urandom(), $urandom(),
                                            nonzero_word(), 32'd0));
                  default: send_block(make_packet($urandom(), $urandom(), $urandom(),
                                                  32'd0, 32'd0));
               endcase
            end else if (pick < 22) begin
               send_block(make_packet($urandom_range(iface_total, 32'hFFFF_FFFF),
                                      $urandom(), $urandom(), nonzero_word(),
                                      nonzero_word()));
            end else begin
               pick = $urandom_range(0, 99);
               lo = $urandom();
               if (pick < 70) hi = $urandom();
               else if (pick < 85) hi = 32'd0;
               else if (pick < 95) hi = $urandom_range(0, 255);
               else begin
                  hi = 32'hFFFF_FFFF;
                  lo = 32'hFFFF_FFFF - $urandom_range(0, 3);
               end
               send_block(make_packet($urandom_range(0, iface_total - 1), hi, lo,
                                      nonzero_word(), nonzero_word()));
            end
         end
      end
      steady_feed = 1'b0;
   endtask

   always @(posedge clock) begin : check_outcomes
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result status=%0d seconds=%0h usec=%0d",
                        rsp_data.status, rsp_data.seconds, rsp_data.microseconds);
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_data.status !== want.status || rsp_data.seconds !== want.seconds ||
                rsp_data.microseconds !== want.microseconds) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected status=%0d seconds=%0h usec=%0d, ",
                            "got status=%0d seconds=%0h usec=%0d"},
                           want.status, want.seconds, want.microseconds,
                           rsp_data.status, rsp_data.seconds, rsp_data.microseconds);
            end
         end
      end
   end

   // counts cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < MAX_INTERFACES; i++) rate_table[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_resolution_decode();
      test_default_rate();
      test_packet_checks();
      test_time_conversion();
      test_random_traffic();
      if (start) start <= 1'b0;
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      mismatches += due_outcomes.size();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
